>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/uct_pkg.sv
// types, codes and character classes of the url component tagger
package uct_pkg;

	// parser states
	typedef enum logic [3:0] {
		ST_SCHEME,
		ST_SLASH1,
		ST_SLASH2,
		ST_UORH,
		ST_PASS,
		ST_HOST,
		ST_V6,
		ST_V6END,
		ST_PORP,
		ST_PORT,
		ST_PATH,
		ST_QUERY,
		ST_FRAG
	} parse_state_t;

	// port digit radix tracking
	typedef enum logic [1:0] {
		OCT_NONE,
		OCT_DEC,
		OCT_OCT,
		OCT_STOP
	} oct_mode_t;

	// component tags
	localparam logic [3:0] TAG_NONE     = 4'd0;
	localparam logic [3:0] TAG_SCHEME   = 4'd1;
	localparam logic [3:0] TAG_UORH     = 4'd2;
	localparam logic [3:0] TAG_PORP     = 4'd3;
	localparam logic [3:0] TAG_USER     = 4'd4;
	localparam logic [3:0] TAG_PASS     = 4'd5;
	localparam logic [3:0] TAG_HOST     = 4'd6;
	localparam logic [3:0] TAG_PORT     = 4'd7;
	localparam logic [3:0] TAG_PATH     = 4'd8;
	localparam logic [3:0] TAG_QUERY    = 4'd9;
	localparam logic [3:0] TAG_FRAG     = 4'd10;

	// resolve codes
	localparam logic [2:0] RES_NONE     = 3'd0;
	localparam logic [2:0] RES_USER     = 3'd1;
	localparam logic [2:0] RES_HOST     = 3'd2;
	localparam logic [2:0] RES_USERPASS = 3'd3;
	localparam logic [2:0] RES_HOSTPORT = 3'd4;

	// error codes
	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_SCHEME   = 4'd1;
	localparam logic [3:0] ERR_SLASH1   = 4'd2;
	localparam logic [3:0] ERR_SLASH2   = 4'd3;
	localparam logic [3:0] ERR_UORH     = 4'd4;
	localparam logic [3:0] ERR_PASS     = 4'd5;
	localparam logic [3:0] ERR_HOST     = 4'd6;
	localparam logic [3:0] ERR_V6       = 4'd7;
	localparam logic [3:0] ERR_PORP     = 4'd8;
	localparam logic [3:0] ERR_PORT     = 4'd9;
	localparam logic [3:0] ERR_LEFTOVER = 4'd10;

	// characters
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;

	// parser flags held between bytes
	typedef struct packed {
		parse_state_t st;
		logic [3:0]   err;
		logic         scheme_seen;
		logic         pend_host;
		logic         host_ne;
		logic         pend_dig;
		oct_mode_t    oct;
		logic         acc_ovf;
		logic         port_ovf;
	} uct_flags_t;

	// per-byte result
	typedef struct packed {
		logic [3:0] tag;
		logic [2:0] res;
	} uct_result_t;

	localparam uct_flags_t FLAGS_RESET = '{
		st: ST_SCHEME, err: ERR_NONE, scheme_seen: 1'b0, pend_host: 1'b0,
		host_ne: 1'b0, pend_dig: 1'b0, oct: OCT_NONE, acc_ovf: 1'b0, port_ovf: 1'b0
	};

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alnum(logic [7:0] c);
		return is_digit(c) || ((c >= CH_LA) && (c <= CH_LZ)) ||
			((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	function automatic logic is_unres(logic [7:0] c);
		return is_alnum(c) || (c == CH_MINUS) || (c == CH_DOT) ||
			(c == CH_USCORE) || (c == CH_TILDE);
	endfunction

	function automatic logic is_v6(logic [7:0] c);
		return is_digit(c) || (c == CH_COLON) || ((c >= CH_LA) && (c <= CH_LF));
	endfunction

endpackage

>>> rtl/url_component_tagger.sv
// Top level of the url component tagger.
// A URL enters one byte per transaction on the s_axis channel, tlast set on
// its final byte. Every byte yields exactly one result transaction on the
// m_axis channel: the component tag, how pending runs resolve, the latched
// error code, the committed port value and its saturation flag, with tlast
// copying the input tlast.
// Throughput is one byte per cycle while the receiver does not stall: the
// parser step is a single pass through a small transition decode and a
// shift-and-add port accumulator between the input and result registers.
// An accepted byte is held in the input register and then in the result
// register, from which its result is offered.
// Reset clears the valid flags of both pipeline registers and returns the
// parser to the scheme state with no error, no pending run and a zero port;
// a byte flagged tlast resets just the parser, so the next byte starts a new URL.
// When the receiver stalls, the result register holds, the byte in the input
// register waits, and s_axis_tready falls once both are occupied.
`include "assert_macros.svh"

module url_component_tagger #(
	parameter int PORT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [3:0] tag, [6:4] resolve, [10:7] error_code,
	                                   // [26:11] port_value, [27] port_overflow
	output logic        m_axis_tlast   // done_res
);
	import uct_pkg::*;

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 last_s1;
	logic                 out_valid_q;
	logic [31:0]          out_data_q;
	logic                 out_last_q;
	uct_flags_t           flags_q;
	logic [PORT_BITS-1:0] acc_q;
	logic [PORT_BITS-1:0] port_q;
	uct_flags_t           flags_nxt;
	logic [PORT_BITS-1:0] acc_nxt;
	logic [PORT_BITS-1:0] port_nxt;
	uct_result_t          result;
	logic [15:0]          port_ext;
	logic                 advance;

	// a byte moves from the input register into the result register
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parser step
	uct_next #(
		.PORT_BITS(PORT_BITS)
	) u_next (
		.cur      (flags_q),
		.acc      (acc_q),
		.port     (port_q),
		.ch       (ch_s1),
		.last     (last_s1),
		.nxt      (flags_nxt),
		.acc_nxt  (acc_nxt),
		.port_nxt (port_nxt),
		.res      (result)
	);

	// parser state, cleared after the last byte of a url
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= FLAGS_RESET;
			acc_q   <= '0;
			port_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				flags_q <= FLAGS_RESET;
				acc_q   <= '0;
				port_q  <= '0;
			end else begin
				flags_q <= flags_nxt;
				acc_q   <= acc_nxt;
				port_q  <= port_nxt;
			end
		end
	end

	// low 16 bits of the port, zero-extended for narrow ports
	assign port_ext = 16'(port_nxt);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0000, flags_nxt.port_ovf, port_ext, flags_nxt.err,
				result.res, result.tag};
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// a byte-level error always suppresses tag and resolve
	`ASSERT_IMPL(a_err_quiet, clk, arst_n,
		out_valid_q && out_data_q[10:7] != ERR_NONE && out_data_q[10:7] != ERR_LEFTOVER,
		out_data_q[3:0] == TAG_NONE && out_data_q[6:4] == RES_NONE)

	// the last byte of a url returns the parser to its start
	`ASSERT_NEXT(a_url_restart, clk, arst_n, advance && last_s1,
		flags_q.st == ST_SCHEME && flags_q.err == ERR_NONE && !flags_q.pend_host)

	// no pending digits means a cleared accumulator
	`ASSERT_IMPL(a_digits_clear, clk, arst_n, !flags_q.pend_dig,
		flags_q.oct == OCT_NONE && acc_q == '0 && !flags_q.acc_ovf)

endmodule

>>> rtl/uct_next.sv
// next-state and tag logic of the url parser for one byte
module uct_next #(
	parameter int PORT_BITS = 16
) (
	input  uct_pkg::uct_flags_t  cur,
	input  logic [PORT_BITS-1:0] acc,
	input  logic [PORT_BITS-1:0] port,
	input  logic [7:0]           ch,
	input  logic                 last,
	output uct_pkg::uct_flags_t  nxt,
	output logic [PORT_BITS-1:0] acc_nxt,
	output logic [PORT_BITS-1:0] port_nxt,
	output uct_pkg::uct_result_t res
);
	import uct_pkg::*;

	localparam int WIDE = PORT_BITS + 4;
	localparam logic [WIDE-1:0] PORT_MAX_W = WIDE'({PORT_BITS{1'b1}});

	logic [WIDE-1:0]      acc_w;
	logic [WIDE-1:0]      mul10;
	logic [WIDE-1:0]      mul8;
	logic [3:0]           dval;
	logic [PORT_BITS-1:0] dig_acc;
	logic                 dig_ovf;
	oct_mode_t            dig_oct;
	logic [3:0]           tag;
	logic [2:0]           rsv;
	logic [3:0]           err;

	// shift-and-add forms of acc*10+d and acc*8+d
	assign dval  = ch[3:0];
	assign acc_w = WIDE'(acc);
	assign mul10 = (acc_w << 3) + (acc_w << 1) + WIDE'(dval);
	assign mul8  = (acc_w << 3) + WIDE'(dval);

	// strtol-style digit accumulation with saturation
	always_comb begin
		dig_acc = acc;
		dig_ovf = cur.acc_ovf;
		dig_oct = cur.oct;
		case (cur.oct)
			OCT_NONE: begin
				dig_oct = (dval == 4'd0) ? OCT_OCT : OCT_DEC;
				dig_acc = PORT_BITS'(dval);
			end
			OCT_DEC: begin
				if (cur.acc_ovf || (mul10 > PORT_MAX_W)) begin
					dig_acc = '1;
					dig_ovf = 1'b1;
				end else begin
					dig_acc = mul10[PORT_BITS-1:0];
				end
			end
			OCT_OCT: begin
				if (dval >= 4'd8) begin
					dig_oct = OCT_STOP;
				end else if (cur.acc_ovf || (mul8 > PORT_MAX_W)) begin
					dig_acc = '1;
					dig_ovf = 1'b1;
				end else begin
					dig_acc = mul8[PORT_BITS-1:0];
				end
			end
			default: begin
				dig_oct = OCT_STOP;
			end
		endcase
	end

	// parser transition
	always_comb begin
		nxt      = cur;
		acc_nxt  = acc;
		port_nxt = port;
		tag      = TAG_NONE;
		rsv      = RES_NONE;
		err      = ERR_NONE;
		if (cur.err == ERR_NONE) begin
			unique case (cur.st)
				ST_SCHEME: begin
					if (is_alnum(ch) || ch == CH_PLUS || ch == CH_MINUS || ch == CH_DOT) begin
						tag = TAG_SCHEME;
						nxt.scheme_seen = 1'b1;
					end else if (ch == CH_COLON) begin
						nxt.st = ST_SLASH1;
					end else if (ch == CH_SLASH && !cur.scheme_seen) begin
						nxt.st = ST_PATH;
					end else begin
						err = ERR_SCHEME;
					end
				end
				ST_SLASH1: begin
					if (ch == CH_SLASH) begin
						nxt.st = ST_SLASH2;
					end else if (is_alnum(ch)) begin
						tag = TAG_UORH;
						nxt.pend_host = 1'b1;
						nxt.st = ST_UORH;
					end else begin
						err = ERR_SLASH1;
					end
				end
				ST_SLASH2: begin
					if (ch == CH_SLASH) begin
						nxt.st = ST_UORH;
					end else begin
						err = ERR_SLASH2;
					end
				end
				ST_UORH: begin
					if (is_unres(ch) || ch == CH_PCT) begin
						tag = TAG_UORH;
						nxt.pend_host = 1'b1;
					end else if (ch == CH_COLON) begin
						nxt.st       = ST_PORP;
						nxt.pend_dig = 1'b0;
						nxt.oct      = OCT_NONE;
						nxt.acc_ovf  = 1'b0;
						acc_nxt      = '0;
					end else if (ch == CH_AT) begin
						rsv = RES_USER;
						nxt.pend_host = 1'b0;
						nxt.st = ST_HOST;
					end else if (ch == CH_SLASH) begin
						rsv = RES_HOST;
						nxt.host_ne   = cur.pend_host;
						nxt.pend_host = 1'b0;
						nxt.st = ST_PATH;
					end else if (ch == CH_LBRK && !cur.pend_host) begin
						nxt.st = ST_V6;
					end else begin
						err = ERR_UORH;
					end
				end
				ST_PASS: begin
					if (is_alnum(ch) || ch == CH_PCT) begin
						tag = TAG_PASS;
					end else if (ch == CH_AT) begin
						nxt.st = ST_HOST;
					end else begin
						err = ERR_PASS;
					end
				end
				ST_HOST: begin
					if (ch == CH_LBRK && !cur.host_ne) begin
						nxt.st = ST_V6;
					end else if (is_unres(ch) || ch == CH_PCT) begin
						tag = TAG_HOST;
						nxt.host_ne = 1'b1;
					end else if (ch == CH_COLON) begin
						nxt.st       = ST_PORT;
						nxt.pend_dig = 1'b0;
						nxt.oct      = OCT_NONE;
						nxt.acc_ovf  = 1'b0;
						acc_nxt      = '0;
					end else if (ch == CH_SLASH) begin
						nxt.st = ST_PATH;
					end else begin
						err = ERR_HOST;
					end
				end
				ST_V6: begin
					if (ch == CH_RBRK) begin
						nxt.st = ST_V6END;
					end else if (is_v6(ch)) begin
						tag = TAG_HOST;
						nxt.host_ne = 1'b1;
					end else begin
						err = ERR_V6;
					end
				end
				ST_V6END: begin
					if (ch == CH_COLON) begin
						nxt.st       = ST_PORT;
						nxt.pend_dig = 1'b0;
						nxt.oct      = OCT_NONE;
						nxt.acc_ovf  = 1'b0;
						acc_nxt      = '0;
					end else if (ch == CH_SLASH) begin
						nxt.st = ST_PATH;
					end else begin
						err = ERR_V6;
					end
				end
				ST_PORP: begin
					if (is_digit(ch)) begin
						tag = TAG_PORP;
						nxt.pend_dig = 1'b1;
						nxt.oct      = dig_oct;
						nxt.acc_ovf  = dig_ovf;
						acc_nxt      = dig_acc;
					end else if (ch == CH_SLASH) begin
						// pending run was host, digits were the port
						rsv = RES_HOSTPORT;
						nxt.host_ne   = cur.pend_host;
						nxt.pend_host = 1'b0;
						port_nxt      = acc;
						nxt.port_ovf  = cur.acc_ovf;
						nxt.pend_dig  = 1'b0;
						nxt.oct       = OCT_NONE;
						nxt.acc_ovf   = 1'b0;
						acc_nxt       = '0;
						nxt.st = ST_PATH;
					end else if (is_alnum(ch) || ch == CH_PCT) begin
						// pending run was user, digits were password
						rsv = RES_USERPASS;
						tag = TAG_PASS;
						nxt.pend_host = 1'b0;
						nxt.pend_dig  = 1'b0;
						nxt.oct       = OCT_NONE;
						nxt.acc_ovf   = 1'b0;
						acc_nxt       = '0;
						nxt.st = ST_PASS;
					end else begin
						err = ERR_PORP;
					end
				end
				ST_PORT: begin
					if (is_digit(ch)) begin
						tag = TAG_PORT;
						nxt.pend_dig = 1'b1;
						nxt.oct      = dig_oct;
						nxt.acc_ovf  = dig_ovf;
						acc_nxt      = dig_acc;
					end else if (ch == CH_SLASH) begin
						port_nxt     = acc;
						nxt.port_ovf = cur.acc_ovf;
						nxt.pend_dig = 1'b0;
						nxt.oct      = OCT_NONE;
						nxt.acc_ovf  = 1'b0;
						acc_nxt      = '0;
						nxt.st = ST_PATH;
					end else begin
						err = ERR_PORT;
					end
				end
				ST_PATH: begin
					if (ch == CH_HASH) begin
						nxt.st = ST_FRAG;
					end else if (ch == CH_QMARK) begin
						nxt.st = ST_QUERY;
					end else begin
						tag = TAG_PATH;
					end
				end
				ST_QUERY: begin
					if (ch == CH_HASH) begin
						nxt.st = ST_FRAG;
					end else if (ch != CH_QMARK) begin
						tag = TAG_QUERY;
					end
				end
				default: begin
					nxt.st = ST_FRAG;
					tag = TAG_FRAG;
				end
			endcase
			if (err != ERR_NONE) begin
				nxt.err = err;
				tag     = TAG_NONE;
				rsv     = RES_NONE;
			end
		end

		// end of url: leftover digits or a pending host run
		if (last && nxt.err == ERR_NONE) begin
			if (nxt.pend_dig) begin
				nxt.err = ERR_LEFTOVER;
			end else if (nxt.pend_host && rsv == RES_NONE) begin
				rsv = RES_HOST;
			end
		end

		res.tag = tag;
		res.res = rsv;
	end

endmodule
